>>> hdl/stepper_trapezoid_move_core_defines.svh
// Assertion macros shared by the stepper move core modules.
// No dependencies; included by the controller and the datapath.
`ifndef STEPPER_TRAPEZOID_MOVE_CORE_DEFINES_SVH
`define STEPPER_TRAPEZOID_MOVE_CORE_DEFINES_SVH

// same-cycle implication
`define STM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define STM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/stm_pkg.sv
// Shared constants, types and codes for the stepper trapezoid move core.
// No dependencies; imported by stm_ctrl, stm_dpath and the top level.
`timescale 1ns / 1ps

package stm_pkg;

    // position arithmetic width (16..48)
    localparam int POS_BITS   = 32;

    localparam int RAMP_W     = 20;
    localparam int LEN_W      = 31;
    localparam int REM_W      = 32;
    localparam int LVL_W      = 7;
    localparam int PER_W      = 11;
    localparam int CMP_W      = 10;

    // remainder unit: RADIX bits of the distance per cycle
    localparam int RADIX      = 4;
    localparam int DIV_STEPS  = (POS_BITS + RADIX - 1) / RADIX;
    localparam int DIV_W      = DIV_STEPS * RADIX;
    localparam int CNT_W      = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    // ramp/100 via reciprocal: floor(ramp * RECIP / 2^RECIP_SHIFT) is exact for 20-bit ramp
    localparam int RECIP_W     = 21;
    localparam int RECIP_SHIFT = 27;
    localparam logic [RECIP_W-1:0] RECIP = 21'd1342178;
    localparam int PROD_W      = RAMP_W + RECIP_W;
    localparam int Q_BITS      = 14;

    localparam logic [PER_W-1:0]  PERIOD_BASE = 11'd1130;
    localparam logic [LVL_W-1:0]  SPEED_SHORT = 7'd30;
    localparam logic [LVL_W-1:0]  LVL_MAX     = 7'd100;
    localparam logic [LVL_W-1:0]  LVL_MIN     = 7'd2;
    localparam logic [RAMP_W-1:0] RAMP_RESET  = 20'd10000;

    // stream widths
    localparam int S_DATA_W   = 72;
    localparam int S_USER_W   = 2;
    localparam int M_DATA_W   = 32;

    // configuration register indexes
    localparam int CFG_IDX_W  = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_SECOND = 2'd1;

    // operation codes
    localparam logic OP_POLL  = 1'b0;
    localparam logic OP_START = 1'b1;

    typedef logic [POS_BITS-1:0] t_pos;

    typedef struct packed {
        logic capture;
        logic load;
        logic diff;
        logic div_step;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_stat;

endpackage

>>> hdl/stm_ctrl.sv
// Sequencer for one request: capture, load, difference, remainder steps, commit.
// Depends on stm_pkg and stepper_trapezoid_move_core_defines.svh.
`timescale 1ns / 1ps
`include "stepper_trapezoid_move_core_defines.svh"

module stm_ctrl
    import stm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_axis_tvalid,
    output logic     o_s_axis_tready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIFF,
        ST_DIV,
        ST_COMMIT
    } t_state;

    t_state             r_state;
    logic               r_ready;
    logic [CNT_W-1:0]   r_cnt;

    assign o_s_axis_tready = r_ready;

    always_comb begin
        o_cmd          = '0;
        o_cmd.capture  = r_ready && i_s_axis_tvalid;
        o_cmd.load     = (r_state == ST_LOAD);
        o_cmd.diff     = (r_state == ST_DIFF);
        o_cmd.div_step = (r_state == ST_DIV);
        o_cmd.commit   = (r_state == ST_COMMIT) && i_stat.out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ready <= 1'b1;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (r_ready && i_s_axis_tvalid) begin
                        r_state <= ST_LOAD;
                        r_ready <= 1'b0;
                    end
                end
                ST_LOAD: begin
                    r_state <= ST_DIFF;
                end
                ST_DIFF: begin
                    r_state <= ST_DIV;
                    r_cnt   <= CNT_W'(DIV_STEPS - 1);
                end
                ST_DIV: begin
                    if (r_cnt == '0) begin
                        r_state <= ST_COMMIT;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                ST_COMMIT: begin
                    // wait for the output register to drain
                    if (i_stat.out_free) begin
                        r_state <= ST_IDLE;
                        r_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                    r_ready <= 1'b1;
                end
            endcase
        end
    end

    `STM_ASSERT_NOW(a_ready_idle, i_clk, i_rst_n, r_ready, r_state == ST_IDLE, "ready outside idle")
    `STM_ASSERT_NEXT(a_accept_load, i_clk, i_rst_n, o_cmd.capture, r_state == ST_LOAD && !r_ready, "accept did not start load")
    `STM_ASSERT_NEXT(a_div_end, i_clk, i_rst_n, r_state == ST_DIV && r_cnt == '0, r_state == ST_COMMIT, "remainder steps overran")
    `STM_ASSERT_NEXT(a_commit_idle, i_clk, i_rst_n, o_cmd.commit, r_state == ST_IDLE && r_ready, "commit did not return to idle")

endmodule

>>> hdl/stm_dpath.sv
// Datapath: per-motor move state, ramp registers, target and distance math,
// radix-16 remainder unit, ramp update and output register. Depends on stm_pkg.
`timescale 1ns / 1ps
`include "stepper_trapezoid_move_core_defines.svh"

module stm_dpath
    import stm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [S_DATA_W-1:0]   i_s_axis_tdata,
    input  logic [S_USER_W-1:0]   i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [M_DATA_W-1:0]   o_m_axis_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [RAMP_W-1:0]     i_cfg_data,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat
);

    // per-motor state
    t_pos              r_base [2];
    logic [REM_W-1:0]  r_rem  [2];
    logic [LVL_W-1:0]  r_lvl  [2];
    logic [LVL_W-1:0]  r_spd  [2];
    logic [RAMP_W-1:0] r_ramp [2];

    // captured request
    logic              r_op;
    logic              r_sel;
    t_pos              r_pos;
    logic [LEN_W-1:0]  r_len;
    logic              r_fwd;
    logic              r_sense;

    // load stage
    t_pos              r_base_e;
    logic [REM_W-1:0]  r_rem_e;
    logic [LVL_W-1:0]  r_lvl_e;
    logic [LVL_W-1:0]  r_spd_e;
    t_pos              r_target;
    logic              r_short;
    logic [PROD_W-1:0] r_qprod;
    logic [RAMP_W-1:0] r_ramp_e;

    // difference stage and remainder unit
    t_pos              r_mag_from, r_mag_to;
    logic              r_neg_from, r_neg_to;
    logic              r_le_from, r_le_to;
    logic              r_at;
    logic [DIV_W-1:0]  r_sh_from, r_sh_to;
    logic [Q_BITS-1:0] r_rf, r_rt;

    // output register
    logic              r_out_valid;
    logic [M_DATA_W-1:0] r_out_data;

    logic              w_start;
    t_pos              w_base_e, w_rem_p, w_target;
    logic [REM_W-1:0]  w_rem_e;
    t_pos              w_dfrom, w_dto, w_mfrom, w_mto;
    logic [Q_BITS-1:0] w_qraw, w_q;
    logic              w_up, w_dn, w_abort;
    logic [LVL_W-1:0]  w_lvl, w_spd;
    logic [PER_W-1:0]  w_spd10, w_period;

    function automatic logic [Q_BITS-1:0] f_mod_step(
        input logic [Q_BITS-1:0] rem_in,
        input logic [RADIX-1:0]  bits,
        input logic [Q_BITS-1:0] q
    );
        logic [Q_BITS:0] acc;
        acc = {1'b0, rem_in};
        for (int k = RADIX - 1; k >= 0; k--) begin
            acc = {acc[Q_BITS-1:0], bits[k]};
            if (acc >= {1'b0, q}) begin
                acc = acc - {1'b0, q};
            end
        end
        return acc[Q_BITS-1:0];
    endfunction

    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_stat.out_free = !r_out_valid || i_m_axis_tready;

    // load: a start replaces the stored move
    assign w_start  = (r_op == OP_START);
    assign w_base_e = w_start ? r_pos : r_base[r_sel];
    assign w_rem_e  = w_start ? REM_W'(r_len) : r_rem[r_sel];
    assign w_rem_p  = POS_BITS'(w_rem_e);
    assign w_target = r_fwd ? (w_base_e + w_rem_p) : (w_base_e - w_rem_p);

    // distances, read as signed and split into sign and magnitude
    assign w_dfrom  = r_fwd ? (r_pos - r_base_e) : (r_base_e - r_pos);
    assign w_dto    = r_fwd ? (r_target - r_pos) : (r_pos - r_target);
    assign w_mfrom  = w_dfrom[POS_BITS-1] ? (t_pos'(0) - w_dfrom) : w_dfrom;
    assign w_mto    = w_dto[POS_BITS-1] ? (t_pos'(0) - w_dto) : w_dto;

    // ramp/100, at least 1
    assign w_qraw   = r_qprod[RECIP_SHIFT +: Q_BITS];
    assign w_q      = (w_qraw == '0) ? Q_BITS'(1) : w_qraw;

    // ramp update
    assign w_up    = (r_rf == '0) && (r_neg_from || r_le_from);
    assign w_dn    = (r_rt == '0) && (r_neg_to || r_le_to);
    assign w_abort = !r_at && !r_sense;

    always_comb begin
        w_lvl = r_lvl_e;
        w_spd = r_spd_e;
        if (r_short) begin
            w_spd = SPEED_SHORT;
        end else if (!r_at) begin
            if (w_up && (w_lvl <= LVL_MAX)) begin
                w_lvl = w_lvl + 1'b1;
                w_spd = w_lvl;
            end
            if (w_dn && (w_lvl >= LVL_MIN)) begin
                w_lvl = w_lvl - 1'b1;
                w_spd = w_lvl;
            end
        end
    end

    assign w_spd10  = PER_W'({w_spd, 3'b000}) + PER_W'({w_spd, 1'b0});
    assign w_period = PERIOD_BASE - w_spd10;

    // motor state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int m = 0; m < 2; m++) begin
                r_base[m] <= '0;
                r_rem[m]  <= '0;
                r_lvl[m]  <= '0;
                r_spd[m]  <= '0;
                r_ramp[m] <= RAMP_RESET;
            end
        end else begin
            if (i_cfg_valid && (i_cfg_index == CFG_RAMP_FIRST)) begin
                r_ramp[0] <= i_cfg_data;
            end
            if (i_cfg_valid && (i_cfg_index == CFG_RAMP_SECOND)) begin
                r_ramp[1] <= i_cfg_data;
            end
            if (i_cmd.commit) begin
                r_base[r_sel] <= w_abort ? r_pos : r_base_e;
                r_rem[r_sel]  <= w_abort ? '0 : r_rem_e;
                r_lvl[r_sel]  <= w_lvl;
                r_spd[r_sel]  <= w_spd;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= i_s_axis_tuser[0];
            r_sel   <= i_s_axis_tuser[1];
            r_pos   <= POS_BITS'(signed'(i_s_axis_tdata[31:0]));
            r_len   <= i_s_axis_tdata[62:32];
            r_fwd   <= i_s_axis_tdata[63];
            r_sense <= i_s_axis_tdata[64];
        end
        if (i_cmd.load) begin
            r_base_e <= w_base_e;
            r_rem_e  <= w_rem_e;
            r_lvl_e  <= w_start ? '0 : r_lvl[r_sel];
            r_spd_e  <= w_start ? '0 : r_spd[r_sel];
            r_target <= w_target;
            r_short  <= (REM_W + 1)'(w_rem_e) < (REM_W + 1)'({r_ramp[r_sel], 1'b0});
            r_qprod  <= PROD_W'(r_ramp[r_sel]) * PROD_W'(RECIP);
            r_ramp_e <= r_ramp[r_sel];
        end
        if (i_cmd.diff) begin
            r_neg_from <= w_dfrom[POS_BITS-1];
            r_neg_to   <= w_dto[POS_BITS-1];
            r_mag_from <= w_mfrom;
            r_mag_to   <= w_mto;
            r_at       <= (w_dto == '0);
            r_sh_from  <= DIV_W'(w_mfrom);
            r_sh_to    <= DIV_W'(w_mto);
            r_rf       <= '0;
            r_rt       <= '0;
        end
        if (i_cmd.div_step) begin
            r_rf      <= f_mod_step(r_rf, r_sh_from[DIV_W-1 -: RADIX], w_q);
            r_rt      <= f_mod_step(r_rt, r_sh_to[DIV_W-1 -: RADIX], w_q);
            r_sh_from <= r_sh_from << RADIX;
            r_sh_to   <= r_sh_to << RADIX;
            r_le_from <= (POS_BITS + RAMP_W)'(r_mag_from) <= (POS_BITS + RAMP_W)'(r_ramp_e);
            r_le_to   <= (POS_BITS + RAMP_W)'(r_mag_to) <= (POS_BITS + RAMP_W)'(r_ramp_e);
        end
        if (i_cmd.commit) begin
            // compare, period, speed, direction, enable, aborted, done
            r_out_data <= {w_period[PER_W-1:1], w_period, w_spd, !r_fwd,
                           !r_at && r_sense, w_abort, r_at};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    `STM_ASSERT_NOW(a_done_abort, i_clk, i_rst_n, r_out_valid, !(r_out_data[0] && r_out_data[1]), "done and aborted together")
    `STM_ASSERT_NEXT(a_commit_valid, i_clk, i_rst_n, i_cmd.commit, r_out_valid, "commit lost its result")
    `STM_ASSERT_NEXT(a_rem_range, i_clk, i_rst_n, i_cmd.div_step, (r_rf < w_q) && (r_rt < w_q), "remainder out of range")

endmodule

>>> hdl/stepper_trapezoid_move_core.sv
// Top level of the two-motor stepper move core with trapezoidal ramp.
// Depends on stm_pkg, stm_ctrl and stm_dpath.
//
// Usage:
//   Requests enter on the s_axis channel: tuser = {motor_select, operation},
//   tdata = position, move_length, move_forward, enable_sense. A start request
//   latches a new move for the selected motor; a poll reports its progress.
//   Each request yields one result on m_axis carrying done, aborted, enable,
//   direction, speed and the step timer period and compare values.
//   Ramp lengths per motor are written on the cfg channel (index 0 motor one,
//   index 1 motor two); the user must write them only while no request is in
//   flight, which the block does not enforce; o_cfg_ready is always high.
//   Each accepted request passes through the load, difference, remainder and
//   commit states before the next is taken; the 4-bit-per-cycle remainder
//   unit tests the distances for multiples of ramp/100.
//   A finished result waits in the output register; a new request is accepted
//   meanwhile, but its commit holds until the receiver takes the old result.
//   Reset (synchronous, active low) clears all moves, levels and speeds and
//   sets both ramp lengths to 10000; no clearing pass is needed.
`timescale 1ns / 1ps

module stepper_trapezoid_move_core
    import stm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // [31:0] position, [62:32] move_length, [63] move_forward,
    // [64] enable_sense, [71:65] zero
    input  logic [S_DATA_W-1:0]   i_s_axis_tdata,
    // [0] operation, [1] motor_select
    input  logic [S_USER_W-1:0]   i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [0] done_res, [1] aborted, [2] enable_out, [3] direction_pin,
    // [10:4] speed_level, [21:11] timer_period, [31:22] timer_compare
    output logic [M_DATA_W-1:0]   o_m_axis_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [RAMP_W-1:0]     i_cfg_data
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    stm_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_stat          (w_stat),
        .o_cmd           (w_cmd)
    );

    stm_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat)
    );

endmodule

>>> tb/sv/tb_stepper_trapezoid_move_core.sv
// Self-checking bench for stepper_trapezoid_move_core: ramp walks, aborts, wraps and ramp settings.
// Depends on stm_pkg and the core RTL; predicts each status result in step with accepted requests.
`timescale 1ns / 1ps

module tb_stepper_trapezoid_move_core;
    import stm_pkg::*;

    localparam int SETTLE_CYCLES = 4 + DIV_STEPS + 16;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    typedef struct packed {
        logic        op;
        logic        motor;
        logic [31:0] position;
        logic [30:0] length;
        logic        fwd;
        logic        sense;
    } t_move_cmd;

    // first member sits in the top bits, so the list runs from the highest field down
    typedef struct packed {
        logic [CMP_W-1:0] timer_compare;
        logic [PER_W-1:0] timer_period;
        logic [LVL_W-1:0] speed_level;
        logic             direction_pin;
        logic             enable_out;
        logic             aborted;
        logic             done_res;
    } t_move_status;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata;
    logic [S_USER_W-1:0]  s_tuser;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [RAMP_W-1:0]    cfg_data = '0;

    t_move_cmd    cur_cmd = '0;
    t_move_cmd    move_cmd_q[$];
    t_move_status move_status_q[$];

    // per-motor shadow of the core
    logic [RAMP_W-1:0] ramp_len[2];
    t_pos              motor_base[2];
    logic [REM_W-1:0]  motor_left[2];
    logic [LVL_W-1:0]  motor_level[2];
    logic [LVL_W-1:0]  motor_vel[2];

    int unsigned send_gap = 0;
    int unsigned recv_gap = 0;
    bit          no_idle = 1'b0;
    int unsigned queued_total = 0;
    int unsigned accepted_total = 0;
    int unsigned results_seen = 0;
    int unsigned done_total = 0;
    int unsigned abort_total = 0;
    int unsigned peak_speed = 0;
    int unsigned mismatch_count = 0;

    assign s_tdata = {{(S_DATA_W - 65){1'b0}}, cur_cmd.sense, cur_cmd.fwd,
                      cur_cmd.length, cur_cmd.position};
    assign s_tuser = {cur_cmd.motor, cur_cmd.op};

    stepper_trapezoid_move_core dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // negative offsets count as inside the ramp; magnitude tested against the divisor
    function automatic bit at_ramp_mark(t_pos d, logic [RAMP_W-1:0] ramp,
                                        longint unsigned quot);
        t_pos mag;
        bit   neg;
        neg = d[POS_BITS-1];
        mag = d;
        if (neg) mag = -d;
        return (mag % quot == 0) && (neg || mag <= ramp);
    endfunction

    function automatic t_move_status advance_motor(t_move_cmd c);
        t_move_status      st;
        logic signed [31:0] pos_s;
        t_pos              pos, tgt, d_from, d_to;
        longint unsigned   quot, left64, ramp64;
        logic [PER_W-1:0]  per;
        int                m;
        m = c.motor;
        pos_s = c.position;
        pos = pos_s;
        quot = ramp_len[m] / 100;
        if (quot == 0) quot = 1;
        if (c.op == OP_START) begin
            motor_base[m] = pos;
            motor_left[m] = {1'b0, c.length};
            motor_vel[m] = '0;
            motor_level[m] = '0;
        end
        if (c.fwd) begin
            tgt = motor_base[m] + motor_left[m];
            d_from = pos - motor_base[m];
            d_to = tgt - pos;
        end else begin
            tgt = motor_base[m] - motor_left[m];
            d_from = motor_base[m] - pos;
            d_to = pos - tgt;
        end
        left64 = motor_left[m];
        ramp64 = ramp_len[m];
        if (left64 < 2 * ramp64) begin
            motor_vel[m] = SPEED_SHORT;
        end else if (pos != tgt) begin
            if (at_ramp_mark(d_from, ramp_len[m], quot) && motor_level[m] <= LVL_MAX) begin
                motor_level[m] = motor_level[m] + 1'b1;
                motor_vel[m] = motor_level[m];
            end
            if (at_ramp_mark(d_to, ramp_len[m], quot) && motor_level[m] >= LVL_MIN) begin
                motor_level[m] = motor_level[m] - 1'b1;
                motor_vel[m] = motor_level[m];
            end
        end
        st = '0;
        st.direction_pin = ~c.fwd;
        if (pos == tgt) begin
            st.done_res = 1'b1;
        end else if (!c.sense) begin
            st.aborted = 1'b1;
            motor_left[m] = '0;
            motor_base[m] = pos;
        end else begin
            st.enable_out = 1'b1;
        end
        per = PERIOD_BASE - motor_vel[m] * 4'd10;
        st.speed_level = motor_vel[m];
        st.timer_period = per;
        st.timer_compare = per[PER_W-1:1];
        return st;
    endfunction

    task automatic flag_mismatch(string what, longint unsigned got, longint unsigned want);
        mismatch_count++;
        $display("mismatch at result %0d: %s got %0d want %0d",
                 results_seen, what, got, want);
    endtask

    task automatic check_status(t_move_status got);
        t_move_status want;
        if (move_status_q.size() == 0) begin
            flag_mismatch("result with no request pending", got, 0);
            return;
        end
        want = move_status_q.pop_front();
        if (got.done_res !== want.done_res)
            flag_mismatch("done_res", got.done_res, want.done_res);
        if (got.aborted !== want.aborted)
            flag_mismatch("aborted", got.aborted, want.aborted);
        if (got.enable_out !== want.enable_out)
            flag_mismatch("enable_out", got.enable_out, want.enable_out);
        if (got.direction_pin !== want.direction_pin)
            flag_mismatch("direction_pin", got.direction_pin, want.direction_pin);
        if (got.speed_level !== want.speed_level)
            flag_mismatch("speed_level", got.speed_level, want.speed_level);
        if (got.timer_period !== want.timer_period)
            flag_mismatch("timer_period", got.timer_period, want.timer_period);
        if (got.timer_compare !== want.timer_compare)
            flag_mismatch("timer_compare", got.timer_compare, want.timer_compare);
        if (want.done_res) done_total++;
        if (want.aborted) abort_total++;
        if (want.speed_level > peak_speed) peak_speed = want.speed_level;
    endtask

    // request driver
    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                move_status_q.push_back(advance_motor(cur_cmd));
                accepted_total++;
            end
            if (s_tvalid && !s_tready) begin
                // hold the request on the bus
            end else if (send_gap != 0) begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end else if (move_cmd_q.size() != 0) begin
                cur_cmd <= move_cmd_q.pop_front();
                s_tvalid <= 1'b1;
                if (!no_idle && $urandom_range(0, 5) == 0)
                    send_gap <= $urandom_range(1, 16);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // status monitor with random back-pressure
    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                check_status(t_move_status'(m_tdata));
            end
            if (recv_gap != 0) begin
                recv_gap <= recv_gap - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (!no_idle && $urandom_range(0, 7) == 0)
                    recv_gap <= $urandom_range(1, 16);
            end
        end
    end

    task automatic queue_cmd(logic op, logic motor, logic [31:0] pos, logic [30:0] len,
                             logic fwd, logic sense);
        t_move_cmd c;
        c.op = op;
        c.motor = motor;
        c.position = pos;
        c.length = len;
        c.fwd = fwd;
        c.sense = sense;
        move_cmd_q.push_back(c);
        queued_total++;
    endtask

    task automatic queue_noise(logic motor);
        logic op;
        op = ($urandom_range(0, 3) == 0) ? OP_START : OP_POLL;
        queue_cmd(op, motor, $urandom, 31'($urandom), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
    endtask

    // one start, then polls walking toward the target on the ramp grid
    task automatic queue_move(logic motor);
        logic [31:0]     origin, spot;
        logic            dir_fwd, sense, poll_fwd;
        longint unsigned ramp, stride_unit, len, k;
        int unsigned     mult_max, pick;
        ramp = ramp_len[motor];
        stride_unit = (ramp / 100 == 0) ? 1 : ramp / 100;
        if (ramp < 100)
            len = $urandom_range(0, 60);
        else if ($urandom_range(0, 3) == 0)
            len = $urandom_range(0, 2 * ramp - 1);
        else
            len = 2 * ramp + $urandom_range(0, ramp / 2);
        mult_max = (len < 2 * ramp) ? 10 : 3;
        origin = $urandom;
        dir_fwd = 1'($urandom_range(0, 1));
        queue_cmd(OP_START, motor, origin, len[30:0], dir_fwd, 1'b1);
        k = 0;
        while (k < len) begin
            k += stride_unit * $urandom_range(1, mult_max);
            if (k > len) k = len;
            spot = dir_fwd ? origin + k[31:0] : origin - k[31:0];
            pick = $urandom_range(0, 29);
            if (pick == 0) begin
                // at or behind the base
                spot = dir_fwd ? origin - 32'(stride_unit * $urandom_range(0, 3))
                               : origin + 32'(stride_unit * $urandom_range(0, 3));
            end else if (pick < 3) begin
                spot = spot + 32'($urandom_range(0, 32'(2 * stride_unit))) - 32'(stride_unit);
            end
            sense = ($urandom_range(0, 59) != 0);
            poll_fwd = ($urandom_range(0, 39) == 0) ? ~dir_fwd : dir_fwd;
            if ($urandom_range(0, 9) == 0) queue_noise(~motor);
            queue_cmd(OP_POLL, motor, spot, 31'($urandom), poll_fwd, sense);
            if (!sense) break;
        end
    endtask

    task automatic queue_phase(int unsigned n);
        int unsigned goal;
        goal = queued_total + n;
        while (queued_total < goal) begin
            if ($urandom_range(0, 4) == 0)
                queue_noise(1'($urandom_range(0, 1)));
            else
                queue_move(1'($urandom_range(0, 1)));
        end
    endtask

    task automatic write_ramp(logic [CFG_IDX_W-1:0] idx, logic [RAMP_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_RAMP_FIRST) ramp_len[0] = val;
        else if (idx == CFG_RAMP_SECOND) ramp_len[1] = val;
        cfg_valid <= 1'b0;
    endtask

    // sender stays quiet until every status has come back
    task automatic wait_idle();
        while (accepted_total != queued_total || move_status_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial begin
        for (int m = 0; m < 2; m++) begin
            ramp_len[m] = RAMP_RESET;
            motor_base[m] = '0;
            motor_left[m] = '0;
            motor_level[m] = '0;
            motor_vel[m] = '0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset state, wraps, wrong-way offsets, abort, done over abort
        queue_cmd(OP_POLL,  1'b0, 32'h0000_0000, 31'h0000_0000, 1'b1, 1'b1);
        queue_cmd(OP_POLL,  1'b1, 32'h0000_0005, 31'h7FFF_FFFF, 1'b0, 1'b0);
        queue_cmd(OP_START, 1'b0, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1, 1'b1);
        queue_cmd(OP_POLL,  1'b0, 32'h8000_0000, 31'h0000_0000, 1'b1, 1'b1);
        queue_cmd(OP_POLL,  1'b0, 32'h7FFF_FF9B, 31'h0000_0000, 1'b1, 1'b1);
        queue_cmd(OP_POLL,  1'b0, 32'h8000_0063, 31'h0000_0000, 1'b1, 1'b1);
        queue_cmd(OP_POLL,  1'b0, 32'hFFFF_FF9A, 31'h0000_0000, 1'b1, 1'b1);
        queue_cmd(OP_POLL,  1'b0, 32'h0000_0062, 31'h0000_0000, 1'b1, 1'b1);
        queue_cmd(OP_POLL,  1'b0, 32'hFFFF_FFFE, 31'h0000_0000, 1'b1, 1'b0);
        queue_cmd(OP_START, 1'b1, 32'hFFFF_FFFF, 31'h0000_0000, 1'b0, 1'b0);
        queue_cmd(OP_START, 1'b1, 32'h0000_1000, 31'd19999,     1'b1, 1'b1);
        queue_cmd(OP_START, 1'b1, 32'h0000_1000, 31'd20000,     1'b0, 1'b1);
        queue_cmd(OP_POLL,  1'b1, 32'hFFFF_D8F0, 31'h0000_0000, 1'b0, 1'b1);
        queue_cmd(OP_POLL,  1'b1, 32'hFFFF_EC78, 31'h0000_0000, 1'b0, 1'b0);
        queue_cmd(OP_POLL,  1'b1, 32'hFFFF_EC78, 31'h0000_0000, 1'b0, 1'b1);
        queue_cmd(OP_START, 1'b0, 32'h8000_0000, 31'h7FFF_FFFF, 1'b0, 1'b0);
        queue_cmd(OP_POLL,  1'b0, 32'h1234_5678, 31'h2AAA_5555, 1'b1, 1'b1);
        wait_idle();

        // shortest ramp: one mark per step
        write_ramp(CFG_RAMP_FIRST, 20'd100);
        write_ramp(CFG_RAMP_SECOND, 20'd100);
        queue_phase(250);
        wait_idle();

        // ramp below 100 falls back to a divisor of 1; spare indexes are ignored
        write_ramp(CFG_RAMP_FIRST, 20'd0);
        write_ramp(CFG_RAMP_SECOND, 20'd37);
        write_ramp(CFG_SPARE_LO, 20'hFFFFF);
        write_ramp(CFG_SPARE_HI, 20'h5A5A5);
        queue_phase(120);
        wait_idle();

        write_ramp(CFG_RAMP_FIRST, 20'hFFFFF);
        write_ramp(CFG_RAMP_SECOND, 20'd250);
        queue_phase(200);
        wait_idle();

        write_ramp(CFG_RAMP_FIRST, RAMP_W'($urandom_range(100, 3000)));
        write_ramp(CFG_RAMP_SECOND, RAMP_W'($urandom_range(100, 3000)));
        queue_phase(250);
        wait_idle();

        // closing stretch at full rate
        no_idle = 1'b1;
        write_ramp(CFG_RAMP_FIRST, RAMP_RESET);
        write_ramp(CFG_RAMP_SECOND, 20'd100);
        queue_phase(150);
        wait_idle();

        $display("%0d requests, %0d results: %0d done, %0d aborted, peak speed %0d",
                 accepted_total, results_seen, done_total, abort_total, peak_speed);
        $display("ramp lengths 0, 37, 100, 250, 10000, 2^20-1 and two random values");
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #6_000_000;
        $display("run limit hit, %0d results outstanding", move_status_q.size());
        $display("tb: failure");
        $finish;
    end

endmodule
